FILE: design/pwrq_pkg.sv
package pwrq_pkg;

  localparam int unsigned QUEUE_WORDS_DEF    = 1024;
  localparam int unsigned MAX_READ_WORDS_DEF = 64;
  localparam int unsigned WORD_W             = 32;
  localparam int unsigned SIZE_W             = WORD_W - 2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic REG_QUEUE_IS_MESSAGE = 1'b0;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BADSIZE = 3'd1,
    ST_NOSPACE = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_DROPPED = 3'd4,
    ST_DISCARD = 3'd5
  } status_e;

  typedef struct packed {
    logic              is_read;
    logic [WORD_W-1:0] data;
  } req_t;

endpackage

FILE: design/pwrq_ram.sv
module pwrq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/pwrq_front.sv
module pwrq_front import pwrq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              op_i,
  input  logic [WORD_W-1:0] data_word_i,
  output logic              head_valid_o,
  output req_t              head_o,
  input  logic              pop_i
);

  req_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;
  req_t       req_in;

  assign in_ready_o   = (count_q != 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = entry_q[rd_ptr_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = pop_i && head_valid_o;

  always_comb begin
    req_in.is_read = (op_i == OP_READ);
    req_in.data    = data_word_i;
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= req_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

FILE: design/pwrq_back.sv
module pwrq_back import pwrq_pkg::*; #(
  parameter int unsigned QUEUE_WORDS    = QUEUE_WORDS_DEF,
  parameter int unsigned MAX_READ_WORDS = MAX_READ_WORDS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              queue_is_message_i,
  input  logic              head_valid_i,
  input  req_t              head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        status_o,
  output logic [WORD_W-1:0] read_word_o,
  output logic              last_word_o,
  output logic              interrupt_request_o,
  output logic              tx_request_seen_o,
  output logic              rx_request_o
);

  localparam int unsigned IW = $clog2(QUEUE_WORDS);
  localparam int unsigned CW = $clog2(QUEUE_WORDS + 1);
  localparam int unsigned RW = $clog2(MAX_READ_WORDS + 1);
  localparam logic [IW-1:0]     QLAST    = IW'(QUEUE_WORDS - 1);
  localparam logic [CW-1:0]     QW_C     = CW'(QUEUE_WORDS);
  localparam logic [SIZE_W-1:0] QW_S     = SIZE_W'(QUEUE_WORDS);
  localparam logic [SIZE_W-1:0] MAXRD_S  = SIZE_W'(MAX_READ_WORDS);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_HDR    = 2'd1;
  localparam logic [1:0] S_STREAM = 2'd2;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p);
    return (p == QLAST) ? '0 : p + 1'b1;
  endfunction

  logic [1:0]    state_q, state_d;
  logic [IW-1:0] read_q, read_d;
  logic [IW-1:0] write_q, write_d;
  logic [IW-1:0] stage_q, stage_d;
  logic [IW-1:0] rd_idx_q, rd_idx_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [RW-1:0] cnt_q, cnt_d;
  logic          disc_q, disc_d;
  logic          tx_q, tx_d;
  logic          rx_q, rx_d;

  logic              out_valid_q, out_valid_d;
  status_e           out_status_q;
  logic [WORD_W-1:0] out_word_q;
  logic              out_last_q, out_irq_q, out_tx_q, out_rx_q;

  logic              load;
  status_e           ld_status;
  logic [WORD_W-1:0] ld_word;
  logic              ld_last, ld_irq, ld_tx, ld_rx;

  logic              ram_we, ram_re;
  logic [IW-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic              can_load;
  logic [SIZE_W-1:0] hdr_size, rd_size;
  logic [CW-1:0]     space;
  logic              size_bad, no_space, rd_bad, empty;

  pwrq_ram #(
    .WIDTH(WORD_W),
    .DEPTH(QUEUE_WORDS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(head_i.data),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign can_load = !out_valid_q || out_ready_i;
  assign hdr_size = head_i.data[WORD_W-1:2];
  assign rd_size  = ram_rdata[WORD_W-1:2];
  assign space    = (write_q >= read_q) ? QW_C - CW'(write_q - read_q)
                                        : CW'(read_q - write_q);
  assign size_bad = (hdr_size == '0) || (hdr_size > QW_S);
  assign no_space = (SIZE_W'(space) <= hdr_size);
  assign rd_bad   = (rd_size == '0) || (rd_size > MAXRD_S);
  assign empty    = (read_q == write_q);

  always_comb begin
    state_d   = state_q;
    read_d    = read_q;
    write_d   = write_q;
    stage_d   = stage_q;
    rd_idx_d  = rd_idx_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    disc_d    = disc_q;
    tx_d      = tx_q;
    rx_d      = rx_q;
    pop_o     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = stage_q;
    ram_re    = 1'b0;
    ram_raddr = rd_idx_q;
    load      = 1'b0;
    ld_status = ST_OK;
    ld_word   = '0;
    ld_last   = 1'b0;
    ld_irq    = 1'b0;
    ld_tx     = 1'b0;
    ld_rx     = rx_q;

    case (state_q)
      S_IDLE: begin
        if (head_valid_i && head_i.is_read) begin
          if (empty) begin
            if (can_load) begin
              pop_o     = 1'b1;
              rx_d      = queue_is_message_i;
              load      = 1'b1;
              ld_status = ST_EMPTY;
              ld_last   = 1'b1;
              ld_rx     = queue_is_message_i;
            end
          end else begin
            pop_o     = 1'b1;
            rx_d      = queue_is_message_i;
            ram_re    = 1'b1;
            ram_raddr = read_q;
            rd_idx_d  = wrap_inc(read_q);
            state_d   = S_HDR;
          end
        end else if (head_valid_i && can_load) begin
          pop_o = 1'b1;
          load  = 1'b1;
          if (disc_q) begin
            rem_d     = rem_q - 1'b1;
            disc_d    = (rem_q != CW'(1));
            ld_status = ST_DISCARD;
            ld_last   = (rem_q == CW'(1));
          end else if (rem_q != '0) begin
            ram_we    = 1'b1;
            ram_waddr = stage_q;
            stage_d   = wrap_inc(stage_q);
            rem_d     = rem_q - 1'b1;
            if (rem_q == CW'(1)) begin
              write_d = wrap_inc(stage_q);
              ld_last = 1'b1;
              ld_irq  = 1'b1;
            end
          end else if (size_bad) begin
            ld_status = ST_BADSIZE;
            ld_last   = 1'b1;
          end else if (no_space) begin
            tx_d      = 1'b1;
            rem_d     = hdr_size[CW-1:0] - 1'b1;
            disc_d    = (hdr_size != SIZE_W'(1));
            ld_status = ST_NOSPACE;
            ld_last   = (hdr_size == SIZE_W'(1));
          end else begin
            tx_d      = 1'b0;
            ram_we    = 1'b1;
            ram_waddr = write_q;
            stage_d   = wrap_inc(write_q);
            rem_d     = hdr_size[CW-1:0] - 1'b1;
            if (hdr_size == SIZE_W'(1)) begin
              write_d = wrap_inc(write_q);
              ld_last = 1'b1;
              ld_irq  = 1'b1;
            end
          end
        end
      end
      S_HDR: begin
        if (can_load) begin
          load  = 1'b1;
          ld_tx = tx_q;
          if (rd_bad) begin
            ld_status = ST_DROPPED;
            ld_last   = 1'b1;
            read_d    = write_q;
            state_d   = S_IDLE;
          end else begin
            ld_word = ram_rdata;
            if (rd_size == SIZE_W'(1)) begin
              ld_last = 1'b1;
              read_d  = rd_idx_q;
              state_d = S_IDLE;
            end else begin
              cnt_d     = rd_size[RW-1:0] - 1'b1;
              ram_re    = 1'b1;
              ram_raddr = rd_idx_q;
              rd_idx_d  = wrap_inc(rd_idx_q);
              state_d   = S_STREAM;
            end
          end
        end
      end
      S_STREAM: begin
        if (can_load) begin
          load    = 1'b1;
          ld_tx   = tx_q;
          ld_word = ram_rdata;
          cnt_d   = cnt_q - 1'b1;
          if (cnt_q == RW'(1)) begin
            ld_last = 1'b1;
            read_d  = rd_idx_q;
            state_d = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = rd_idx_q;
            rd_idx_d  = wrap_inc(rd_idx_q);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_status_q <= ld_status;
      out_word_q   <= ld_word;
      out_last_q   <= ld_last;
      out_irq_q    <= ld_irq;
      out_tx_q     <= ld_tx;
      out_rx_q     <= ld_rx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      read_q      <= '0;
      write_q     <= '0;
      stage_q     <= '0;
      rd_idx_q    <= '0;
      rem_q       <= '0;
      cnt_q       <= '0;
      disc_q      <= 1'b0;
      tx_q        <= 1'b0;
      rx_q        <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      read_q      <= read_d;
      write_q     <= write_d;
      stage_q     <= stage_d;
      rd_idx_q    <= rd_idx_d;
      rem_q       <= rem_d;
      cnt_q       <= cnt_d;
      disc_q      <= disc_d;
      tx_q        <= tx_d;
      rx_q        <= rx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = out_status_q;
  assign read_word_o         = out_word_q;
  assign last_word_o         = out_last_q;
  assign interrupt_request_o = out_irq_q;
  assign tx_request_seen_o   = out_tx_q;
  assign rx_request_o        = out_rx_q;

endmodule

FILE: design/packet_word_ring_queue_core.sv
// A write word or an empty read passes the front entry register, then the output register;
// a packet read passes it, the registered ring read port and the output register, then gives
// one word a cycle while the output is taken. Throughput: one write word per cycle while the
// output is taken; a packet read holds the back end until its last word or its DROPPED result.
// Reset: indexes, counters and tx flag clear, rx flag and queue_is_message set to one;
// ring contents stay undefined until written, so no clearing pass runs.
module packet_word_ring_queue_core import pwrq_pkg::*; #(
  parameter int unsigned QUEUE_WORDS    = QUEUE_WORDS_DEF,
  parameter int unsigned MAX_READ_WORDS = MAX_READ_WORDS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              op_i,
  input  logic [WORD_W-1:0] data_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        status_o,
  output logic [WORD_W-1:0] read_word_o,
  output logic              last_word_o,
  output logic              interrupt_request_o,
  output logic              tx_request_seen_o,
  output logic              rx_request_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic qmsg_q;
  logic reg_sel;
  logic head_valid;
  req_t head;
  logic pop;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_QUEUE_IS_MESSAGE);
  assign prdata  = reg_sel ? {31'd0, qmsg_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qmsg_q <= 1'b1;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      qmsg_q <= pwdata[0];
    end
  end

  pwrq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .data_word_i (data_word_i),
    .head_valid_o(head_valid),
    .head_o      (head),
    .pop_i       (pop)
  );

  pwrq_back #(
    .QUEUE_WORDS   (QUEUE_WORDS),
    .MAX_READ_WORDS(MAX_READ_WORDS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .queue_is_message_i (qmsg_q),
    .head_valid_i       (head_valid),
    .head_i             (head),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_o           (status_o),
    .read_word_o        (read_word_o),
    .last_word_o        (last_word_o),
    .interrupt_request_o(interrupt_request_o),
    .tx_request_seen_o  (tx_request_seen_o),
    .rx_request_o       (rx_request_o)
  );

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

typedef struct packed {
  logic [2:0]  status;
  logic [31:0] word;
  logic        last;
  logic        irq;
  logic        tx_seen;
  logic        rx;
} ring_result_t;

class ring_queue_scoreboard;
  localparam int unsigned QW     = pwrq_pkg::QUEUE_WORDS_DEF;
  localparam int unsigned MAX_RD = pwrq_pkg::MAX_READ_WORDS_DEF;
  localparam int unsigned IDX_W  = $clog2(QW);

  logic [31:0]      ring_mem [QW];
  logic [IDX_W-1:0] rd_ptr;
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] stage_ptr;
  logic [IDX_W:0]   left_words;
  logic             dropping_rest;
  logic             tx_flag;
  logic             rx_flag;
  logic             msg_queue;
  ring_result_t     pending_results[$];
  int               errors;

  function new();
    rd_ptr        = '0;
    wr_ptr        = '0;
    stage_ptr     = '0;
    left_words    = '0;
    dropping_rest = 1'b0;
    tx_flag       = 1'b0;
    rx_flag       = 1'b1;
    msg_queue     = 1'b1;
    errors        = 0;
  endfunction

  function int unsigned free_words();
    if (wr_ptr >= rd_ptr) return QW - (32'(wr_ptr) - 32'(rd_ptr));
    return 32'(rd_ptr) - 32'(wr_ptr);
  endfunction

  function bit in_packet();
    return left_words != 0;
  endfunction

  function bit ring_empty();
    return rd_ptr == wr_ptr;
  endfunction

  function void add_expected(pwrq_pkg::status_e st, logic [31:0] w, logic last, logic irq,
                             logic txs);
    ring_result_t r;
    r.status  = st;
    r.word    = w;
    r.last    = last;
    r.irq     = irq;
    r.tx_seen = txs;
    r.rx      = rx_flag;
    pending_results.push_back(r);
  endfunction

  function void model_write(logic [31:0] w);
    logic [29:0] size;
    if (dropping_rest) begin
      left_words = left_words - 1'b1;
      if (left_words == 0) dropping_rest = 1'b0;
      add_expected(pwrq_pkg::ST_DISCARD, '0, !dropping_rest, 1'b0, 1'b0);
      return;
    end
    if (left_words != 0) begin
      ring_mem[stage_ptr] = w;
      stage_ptr  = stage_ptr + 1'b1;
      left_words = left_words - 1'b1;
      if (left_words == 0) begin
        wr_ptr = stage_ptr;
        add_expected(pwrq_pkg::ST_OK, '0, 1'b1, 1'b1, 1'b0);
      end else begin
        add_expected(pwrq_pkg::ST_OK, '0, 1'b0, 1'b0, 1'b0);
      end
      return;
    end
    size = w[31:2];
    if (size == 0 || size > QW) begin
      add_expected(pwrq_pkg::ST_BADSIZE, '0, 1'b1, 1'b0, 1'b0);
      return;
    end
    if (free_words() <= size) begin
      tx_flag       = 1'b1;
      left_words    = (IDX_W+1)'(size - 1);
      dropping_rest = (left_words != 0);
      add_expected(pwrq_pkg::ST_NOSPACE, '0, !dropping_rest, 1'b0, 1'b0);
      return;
    end
    tx_flag          = 1'b0;
    ring_mem[wr_ptr] = w;
    stage_ptr        = wr_ptr + 1'b1;
    left_words       = (IDX_W+1)'(size - 1);
    if (left_words == 0) begin
      wr_ptr = stage_ptr;
      add_expected(pwrq_pkg::ST_OK, '0, 1'b1, 1'b1, 1'b0);
    end else begin
      add_expected(pwrq_pkg::ST_OK, '0, 1'b0, 1'b0, 1'b0);
    end
  endfunction

  function void model_read();
    logic [29:0]      size;
    logic [IDX_W-1:0] p;
    rx_flag = msg_queue;
    if (rd_ptr == wr_ptr) begin
      add_expected(pwrq_pkg::ST_EMPTY, '0, 1'b1, 1'b0, 1'b0);
      return;
    end
    size = ring_mem[rd_ptr][31:2];
    if (size == 0 || size > MAX_RD) begin
      rd_ptr = wr_ptr;
      add_expected(pwrq_pkg::ST_DROPPED, '0, 1'b1, 1'b0, tx_flag);
      return;
    end
    p = rd_ptr;
    for (int unsigned k = 0; k < size; k++) begin
      add_expected(pwrq_pkg::ST_OK, ring_mem[p], (k + 1) == size, 1'b0, tx_flag);
      p = p + 1'b1;
    end
    rd_ptr = p;
  endfunction

  function void take_request(logic op, logic [31:0] w);
    if (op == pwrq_pkg::OP_READ) model_read();
    else model_write(w);
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 40) $display("%0t mismatch: %s", $time, msg);
  endtask

  task check_result(logic [2:0] st, logic [31:0] w, logic last, logic irq, logic txs,
                    logic rx);
    ring_result_t e;
    if (pending_results.size() == 0) begin
      report($sformatf("unexpected result status %0d word %08h", st, w));
      return;
    end
    e = pending_results.pop_front();
    if (st !== e.status) report($sformatf("status got %0d want %0d", st, e.status));
    if (w !== e.word) report($sformatf("read_word got %08h want %08h", w, e.word));
    if (last !== e.last) report($sformatf("last_word got %0b want %0b", last, e.last));
    if (irq !== e.irq) report($sformatf("interrupt_request got %0b want %0b", irq, e.irq));
    if (txs !== e.tx_seen)
      report($sformatf("tx_request_seen got %0b want %0b", txs, e.tx_seen));
    if (rx !== e.rx) report($sformatf("rx_request got %0b want %0b", rx, e.rx));
  endtask
endclass

module tb;
  import pwrq_pkg::*;

  localparam int          WATCHDOG_LIMIT = 2000;
  localparam logic [2:0]  REG_ADDR       = {REG_QUEUE_IS_MESSAGE, 2'b00};

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              op_i;
  logic [WORD_W-1:0] data_word_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [2:0]        status_o;
  logic [WORD_W-1:0] read_word_o;
  logic              last_word_o;
  logic              interrupt_request_o;
  logic              tx_request_seen_o;
  logic              rx_request_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  ring_queue_scoreboard sb;
  bit                   quiet;
  int unsigned          items_sent;
  int                   ready_left = 0;
  int                   idle_cycles = 0;

  packet_word_ring_queue_core dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .op_i                (op_i),
    .data_word_i         (data_word_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .status_o            (status_o),
    .read_word_o         (read_word_o),
    .last_word_o         (last_word_o),
    .interrupt_request_o (interrupt_request_o),
    .tx_request_seen_o   (tx_request_seen_o),
    .rx_request_o        (rx_request_o),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(status_o, read_word_o, last_word_o, interrupt_request_o,
                      tx_request_seen_o, rx_request_o);
    end
    if (ready_left == 0) begin
      if (quiet || $urandom_range(0, 99) < 60) begin
        out_ready_i <= 1'b1;
        ready_left = $urandom_range(1, 12);
      end else begin
        out_ready_i <= 1'b0;
        ready_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                 : $urandom_range(1, 3);
      end
    end else begin
      ready_left--;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int gap_cycles();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] body_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(logic op, logic [31:0] w);
    int gap;
    gap = gap_cycles();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    op_i        <= op;
    data_word_i <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.take_request(op, w);
    items_sent++;
  endtask

  task automatic send_read();
    send_item(OP_READ, $urandom);
  endtask

  task automatic send_packet(int unsigned n_words, bit mix_reads);
    send_item(OP_WRITE, 32'(n_words << 2) | 32'($urandom_range(0, 3)));
    for (int unsigned i = 1; i < n_words; i++) begin
      if (mix_reads && $urandom_range(0, 19) == 0) send_read();
      send_item(OP_WRITE, body_word());
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == REG_ADDR) sb.msg_queue = value[0];
  endtask

  task automatic apb_check(logic [2:0] addr, logic want);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got[0] !== want) sb.report($sformatf("queue_is_message read %0b want %0b", got[0], want));
  endtask

  task automatic set_queue_type(bit msg);
    drain();
    apb_write(REG_ADDR, 32'(msg));
    @(posedge clk_i);
    apb_check(REG_ADDR, msg);
  endtask

  task automatic directed_items();
    send_read();
    send_item(OP_WRITE, 32'h0000_0000);
    send_item(OP_WRITE, 32'h0000_0003);
    send_item(OP_WRITE, 32'hFFFF_FFFF);
    send_item(OP_WRITE, 32'(1025 << 2));
    send_item(OP_WRITE, 32'h0000_0007);
    send_read();
    send_item(OP_WRITE, 32'd12);
    send_item(OP_WRITE, 32'hFFFF_FFFF);
    send_item(OP_WRITE, 32'h0000_0000);
    send_read();
    send_item(OP_WRITE, 32'd8);
    send_read();
    send_item(OP_WRITE, 32'hA5A5_5A5A);
    send_read();
    send_read();
  endtask

  task automatic random_traffic(int unsigned count);
    int unsigned stop;
    int unsigned pick;
    int unsigned n;
    int unsigned size;
    stop = items_sent + count;
    while (items_sent < stop) begin
      if ($urandom_range(0, 19) == 0) quiet = !quiet;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        n = $urandom_range(0, 19);
        if (n < 14) size = $urandom_range(1, 8);
        else if (n < 18) size = $urandom_range(9, 40);
        else if (n == 18) size = MAX_READ_WORDS_DEF;
        else size = $urandom_range(MAX_READ_WORDS_DEF + 1, MAX_READ_WORDS_DEF + 8);
        send_packet(size, 1'b1);
      end else if (pick < 80) begin
        send_read();
      end else if (pick < 88) begin
        case ($urandom_range(0, 2))
          0:       send_item(OP_WRITE, 32'($urandom_range(0, 3)));
          1:       send_item(OP_WRITE, $urandom | 32'h8000_0000);
          default: send_item(OP_WRITE, 32'(1025 << 2) | 32'($urandom_range(0, 3)));
        endcase
      end else if (pick < 97) begin
        send_item(1'($urandom_range(0, 1)), $urandom);
      end else begin
        drain();
      end
    end
  endtask

  task automatic overflow_tail();
    quiet = 1'b0;
    while (sb.in_packet()) send_item(OP_WRITE, body_word());
    while (!sb.ring_empty()) send_read();
    send_packet(3, 1'b0);
    send_item(OP_WRITE, 32'(QUEUE_WORDS_DEF << 2));
    repeat (6) send_item(OP_WRITE, body_word());
    send_read();
    send_read();
    send_item(OP_WRITE, body_word());
    send_read();
  endtask

  initial begin
    sb          = new();
    quiet       = 1'b0;
    items_sent  = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    op_i        = OP_WRITE;
    data_word_i = '0;
    out_ready_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_check(REG_ADDR, 1'b1);
    directed_items();
    set_queue_type(1'b0);
    random_traffic(50);
    set_queue_type(1'b1);
    random_traffic(50);
    set_queue_type(1'b0);
    random_traffic(15);
    overflow_tail();
    in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
